// ----- hdl/npt_pkg.sv -----
// ----------------------------------------------------------------------------
// Palette trainer package
// Shared types, codes and widths of the neural palette trainer.
// ----------------------------------------------------------------------------
package npt_pkg;

   localparam int unsigned CHAN_W     = 12;
   localparam int unsigned MEM_W      = 3 * CHAN_W;
   localparam int unsigned DIV_NUM_W  = 30;
   localparam int unsigned DIV_DEN_W  = 24;
   localparam int unsigned DIV_CNT_W  = 5;
   localparam int unsigned CSR_ADDR_W = 5;

   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_EPOCH = 2'd1;
   localparam logic [1:0] OP_TRAIN = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic [2:0] REG_NEURON_COUNT   = 3'd0;
   localparam logic [2:0] REG_SAMPLE_COUNT   = 3'd1;
   localparam logic [2:0] REG_ALPHA_DIVISOR  = 3'd2;
   localparam logic [2:0] REG_DECAY_INTERVAL = 3'd3;
   localparam logic [2:0] REG_START_RADIUS   = 3'd4;

   localparam logic [10:0] LEARN_RATE_START = 11'd1024;

   typedef struct packed {
      logic [8:0]  neuron_count;
      logic [23:0] sample_count;
      logic [6:0]  alpha_divisor;
      logic [17:0] decay_interval;
      logic [5:0]  start_radius;
   } npt_cfg_type;

   typedef struct packed {
      logic accept;
      logic init_start;
      logic div_init;
      logic init_write;
      logic epoch;
      logic scan_start;
      logic scan_run;
      logic upd_start;
      logic upd_read;
      logic upd_mul;
      logic upd_write;
      logic div_alpha;
      logic alpha_write;
      logic div_rad;
      logic rad_write;
      logic dec_finish;
      logic rd_read;
      logic out_load;
   } npt_cmd_type;

   typedef struct packed {
      logic div_done;
      logic init_last;
      logic scan_done;
      logic upd_last;
      logic cd_zero;
      logic rad_live;
      logic out_free;
   } npt_status_type;

endpackage

// ----- hdl/neural_palette_trainer_core.sv -----
// ----------------------------------------------------------------------------
// Neural palette trainer core
// Trains a palette of 12-bit RGB neurons on pixels and reads entries back.
// ----------------------------------------------------------------------------
// One word is taken at a time, and the next is taken once the current one has
// finished, even while its result word still waits on rsp_stall. A train word
// runs the nearest-neuron scan, a read, multiply and write for each neighbor
// update (the winner plus up to 2 * radius + 1 neighbors, one memory port), and
// on a decay step up to two passes through the one-bit-per-cycle divider. An
// init word runs one division per neuron through the same divider.
module neural_palette_trainer_core #(
   parameter int unsigned MAX_NEURONS = 256,
   parameter int unsigned SAMPLE_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_op,
   input  logic [7:0]                      req_pixel_red,
   input  logic [7:0]                      req_pixel_green,
   input  logic [7:0]                      req_pixel_blue,
   input  logic [7:0]                      req_entry_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_winner_index,
   output logic [7:0]                      rsp_palette_red,
   output logic [7:0]                      rsp_palette_green,
   output logic [7:0]                      rsp_palette_blue,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [npt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import npt_pkg::*;

   npt_cfg_type    cfg_ff, cfg_in;
   npt_cmd_type    cmd;
   npt_status_type status;
   logic [2:0]     reg_idx;
   logic           csr_wr;

   assign reg_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (reg_idx)
            REG_NEURON_COUNT:   cfg_in.neuron_count   = csr_pwdata[8:0];
            REG_SAMPLE_COUNT:   cfg_in.sample_count   = csr_pwdata[23:0];
            REG_ALPHA_DIVISOR:  cfg_in.alpha_divisor  = csr_pwdata[6:0];
            REG_DECAY_INTERVAL: cfg_in.decay_interval = csr_pwdata[17:0];
            REG_START_RADIUS:   cfg_in.start_radius   = csr_pwdata[5:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_NEURON_COUNT:   csr_prdata = 32'(cfg_ff.neuron_count);
         REG_SAMPLE_COUNT:   csr_prdata = 32'(cfg_ff.sample_count);
         REG_ALPHA_DIVISOR:  csr_prdata = 32'(cfg_ff.alpha_divisor);
         REG_DECAY_INTERVAL: csr_prdata = 32'(cfg_ff.decay_interval);
         REG_START_RADIUS:   csr_prdata = 32'(cfg_ff.start_radius);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neuron_count   <= 9'd256;
         cfg_ff.sample_count   <= 24'd52428;
         cfg_ff.alpha_divisor  <= 7'd31;
         cfg_ff.decay_interval <= 18'd524;
         cfg_ff.start_radius   <= 6'd32;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   npt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd)
   );

   npt_dp #(
      .MAX_NEURONS (MAX_NEURONS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg_ff),
      .status            (status),
      .req_op            (req_op),
      .req_pixel_red     (req_pixel_red),
      .req_pixel_green   (req_pixel_green),
      .req_pixel_blue    (req_pixel_blue),
      .req_entry_index   (req_entry_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_winner_index  (rsp_winner_index),
      .rsp_palette_red   (rsp_palette_red),
      .rsp_palette_green (rsp_palette_green),
      .rsp_palette_blue  (rsp_palette_blue)
   );

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("a word was taken while the previous one was still in work");

   a_winner_excludes_palette: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_winner_index != 8'd0) |->
         (rsp_palette_red == 8'd0 && rsp_palette_green == 8'd0 &&
          rsp_palette_blue == 8'd0))
      else $error("a train result carries palette data");

   a_single_load: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && rsp_valid) |-> !rsp_stall)
      else $error("a result word was overwritten before it was taken");
`endif

endmodule

// ----- hdl/npt_div.sv -----
// ----------------------------------------------------------------------------
// Palette trainer divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module npt_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [npt_pkg::DIV_NUM_W-1:0] num,
   input  logic [npt_pkg::DIV_DEN_W-1:0] den,
   output logic                          done,
   output logic [npt_pkg::DIV_NUM_W-1:0] quot
);
   import npt_pkg::*;

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   trial_sub;

   always_comb begin
      trial     = {rem_ff, quo_ff[DIV_NUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial_sub[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ----- hdl/npt_dp.sv -----
// ----------------------------------------------------------------------------
// Palette trainer datapath
// Neuron memory, nearest-neuron scan, neighbor update, decay and result word.
// ----------------------------------------------------------------------------
module npt_dp #(
   parameter int unsigned MAX_NEURONS = 256,
   parameter int unsigned SAMPLE_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  npt_pkg::npt_cmd_type    cmd,
   input  npt_pkg::npt_cfg_type    cfg,
   output npt_pkg::npt_status_type status,
   input  logic [1:0]              req_op,
   input  logic [7:0]              req_pixel_red,
   input  logic [7:0]              req_pixel_green,
   input  logic [7:0]              req_pixel_blue,
   input  logic [7:0]              req_entry_index,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_winner_index,
   output logic [7:0]              rsp_palette_red,
   output logic [7:0]              rsp_palette_green,
   output logic [7:0]              rsp_palette_blue
);
   import npt_pkg::*;

   localparam int unsigned IDX_W  = $clog2(MAX_NEURONS);
   localparam int unsigned CNT_W  = $clog2(MAX_NEURONS + 1);
   localparam int unsigned NB_W   = 10;
   localparam int unsigned DIST_W = 14;
   localparam int unsigned PROD_W = 23;
   localparam int unsigned WIDE_W = 33;

   logic [CNT_W-1:0]   act_cnt;
   logic [CNT_W-1:0]   last_idx;

   logic [1:0]         op_ff, op_in;
   logic [CHAN_W-1:0]  pix_ff [3];
   logic [CHAN_W-1:0]  pix_in [3];
   logic               idx_ok_ff, idx_ok_in;
   logic [IDX_W-1:0]   ridx_ff, ridx_in;

   logic [MEM_W-1:0]   mem [MAX_NEURONS];
   logic [MEM_W-1:0]   rdata_ff;
   logic               mem_we, mem_re;
   logic [IDX_W-1:0]   mem_waddr, mem_raddr;
   logic [MEM_W-1:0]   mem_wdata;
   logic [CHAN_W-1:0]  chan_v [3];

   logic [CNT_W-1:0]   init_i_ff, init_i_in;
   logic [CNT_W-1:0]   scan_addr_ff, scan_addr_in;
   logic               issue_ff, issue_in;
   logic [IDX_W-1:0]   eval_idx_ff, eval_idx_in;
   logic [IDX_W-1:0]   best_ff, best_in;
   logic [DIST_W-1:0]  bestd_ff, bestd_in;
   logic               scan_more;
   logic [DIST_W-1:0]  dsum;
   logic [CHAN_W-1:0]  adiff [3];

   logic               first_ff, first_in;
   logic [NB_W-1:0]    k_ff, k_in;
   logic [NB_W-1:0]    hi_ff, hi_in;
   logic signed [NB_W-1:0] lo_c, hi_c, top_c;
   logic [IDX_W-1:0]   tgt;
   logic               ge_ff [3];
   logic               ge_in [3];
   logic [PROD_W-1:0]  prod_ff [3];
   logic [PROD_W-1:0]  prod_in [3];
   logic [CHAN_W-1:0]  mdiff [3];
   logic [CHAN_W-1:0]  newv [3];

   logic [10:0]            lr_ff, lr_in;
   logic [5:0]             rad_ff, rad_in;
   logic [SAMPLE_BITS-1:0] seen_ff, seen_in;
   logic [17:0]            cd_ff, cd_in;
   logic [WIDE_W-1:0]      seen_w, sc_w, left_w;
   logic [23:0]            left;
   logic [DIV_NUM_W-1:0]   rad_num;
   logic [6:0]             adiv_eff;
   logic [17:0]            ivl_eff;

   logic                   div_start, div_done;
   logic [DIV_NUM_W-1:0]   div_num, div_quot;
   logic [DIV_DEN_W-1:0]   div_den;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] win_ff, win_in;
   logic [7:0] pr_ff, pr_in, pg_ff, pg_in, pb_ff, pb_in;

   npt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      if (cfg.neuron_count == '0) begin
         act_cnt = CNT_W'(1);
      end else if (cfg.neuron_count > 9'(MAX_NEURONS)) begin
         act_cnt = CNT_W'(MAX_NEURONS);
      end else begin
         act_cnt = cfg.neuron_count[CNT_W-1:0];
      end
      last_idx = act_cnt - 1'b1;
      adiv_eff = (cfg.alpha_divisor == '0) ? 7'd1 : cfg.alpha_divisor;
      ivl_eff  = (cfg.decay_interval == '0) ? 18'd1 : cfg.decay_interval;
      seen_w   = WIDE_W'(seen_ff);
      sc_w     = WIDE_W'(cfg.sample_count);
      left_w   = sc_w - seen_w;
      left     = left_w[23:0];
      rad_num  = cfg.start_radius * left;
   end

   always_comb begin
      chan_v[0] = rdata_ff[3*CHAN_W-1:2*CHAN_W];
      chan_v[1] = rdata_ff[2*CHAN_W-1:CHAN_W];
      chan_v[2] = rdata_ff[CHAN_W-1:0];
      for (int c = 0; c < 3; c++) begin
         adiff[c] = (chan_v[c] >= pix_ff[c]) ? chan_v[c] - pix_ff[c]
                                             : pix_ff[c] - chan_v[c];
         ge_in[c] = chan_v[c] >= pix_ff[c];
         mdiff[c] = adiff[c];
         prod_in[c] = lr_ff * mdiff[c];
         newv[c] = ge_ff[c] ? chan_v[c] - prod_ff[c][21:10]
                            : chan_v[c] + prod_ff[c][21:10];
      end
      dsum = DIST_W'(adiff[0]) + DIST_W'(adiff[1]) + DIST_W'(adiff[2]);
   end

   always_comb begin
      scan_more = scan_addr_ff < act_cnt;
      tgt       = first_ff ? best_ff : k_ff[IDX_W-1:0];
      lo_c      = $signed(NB_W'(best_ff)) - $signed(NB_W'(rad_ff));
      hi_c      = $signed(NB_W'(best_ff)) + $signed(NB_W'(rad_ff));
      top_c     = $signed(NB_W'(last_idx));

      mem_re    = (cmd.scan_run && scan_more) || cmd.upd_read || cmd.rd_read;
      if (cmd.scan_run) begin
         mem_raddr = scan_addr_ff[IDX_W-1:0];
      end else if (cmd.upd_read) begin
         mem_raddr = tgt;
      end else begin
         mem_raddr = ridx_ff;
      end
      mem_we = cmd.init_write || cmd.upd_write;
      if (cmd.init_write) begin
         mem_waddr = init_i_ff[IDX_W-1:0];
         mem_wdata = {3{div_quot[CHAN_W-1:0]}};
      end else begin
         mem_waddr = tgt;
         mem_wdata = {newv[0], newv[1], newv[2]};
      end

      div_start = cmd.div_init || cmd.div_alpha || cmd.div_rad;
      if (cmd.div_init) begin
         div_num = DIV_NUM_W'({init_i_ff, 12'd0});
         div_den = DIV_DEN_W'(act_cnt);
      end else if (cmd.div_alpha) begin
         div_num = DIV_NUM_W'(lr_ff);
         div_den = DIV_DEN_W'(adiv_eff);
      end else begin
         div_num = rad_num;
         div_den = cfg.sample_count;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      op_in        = op_ff;
      pix_in       = pix_ff;
      idx_ok_in    = idx_ok_ff;
      ridx_in      = ridx_ff;
      init_i_in    = init_i_ff;
      scan_addr_in = scan_addr_ff;
      issue_in     = issue_ff;
      eval_idx_in  = eval_idx_ff;
      best_in      = best_ff;
      bestd_in     = bestd_ff;
      first_in     = first_ff;
      k_in         = k_ff;
      hi_in        = hi_ff;
      lr_in        = lr_ff;
      rad_in       = rad_ff;
      seen_in      = seen_ff;
      cd_in        = cd_ff;
      rsp_valid_in = rsp_valid_ff;
      win_in       = win_ff;
      pr_in        = pr_ff;
      pg_in        = pg_ff;
      pb_in        = pb_ff;

      if (cmd.accept) begin
         op_in     = req_op;
         pix_in[0] = {req_pixel_red, 4'd0};
         pix_in[1] = {req_pixel_green, 4'd0};
         pix_in[2] = {req_pixel_blue, 4'd0};
         idx_ok_in = {1'b0, req_entry_index} < 9'(MAX_NEURONS);
         ridx_in   = req_entry_index[IDX_W-1:0];
      end
      if (cmd.init_start) begin
         init_i_in = '0;
      end
      if (cmd.init_write) begin
         init_i_in = init_i_ff + 1'b1;
      end
      if (cmd.epoch) begin
         lr_in   = LEARN_RATE_START;
         rad_in  = '0;
         seen_in = '0;
         cd_in   = '0;
      end
      if (cmd.scan_start) begin
         scan_addr_in = '0;
         issue_in     = 1'b0;
         best_in      = '0;
         bestd_in     = '1;
      end
      if (cmd.scan_run) begin
         if (scan_more) begin
            scan_addr_in = scan_addr_ff + 1'b1;
            issue_in     = 1'b1;
            eval_idx_in  = scan_addr_ff[IDX_W-1:0];
         end else begin
            issue_in = 1'b0;
         end
         if (issue_ff && dsum < bestd_ff) begin
            bestd_in = dsum;
            best_in  = eval_idx_ff;
         end
      end
      if (cmd.upd_start) begin
         first_in = 1'b1;
         k_in     = (lo_c < 0) ? '0 : lo_c;
         hi_in    = (hi_c > top_c) ? top_c : hi_c;
      end
      if (cmd.upd_write) begin
         if (first_ff) begin
            first_in = 1'b0;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
      if (cmd.alpha_write) begin
         lr_in = lr_ff - div_quot[10:0];
      end
      if (cmd.rad_write) begin
         if (status.rad_live && div_quot > DIV_NUM_W'(1)) begin
            rad_in = div_quot[5:0];
         end else begin
            rad_in = '0;
         end
      end
      if (cmd.dec_finish) begin
         cd_in = (cd_ff == '0) ? ivl_eff - 1'b1 : cd_ff - 1'b1;
         if (seen_ff != '1) begin
            seen_in = seen_ff + 1'b1;
         end
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         win_in       = (op_ff == OP_TRAIN) ? 8'(best_ff) : 8'd0;
         if (op_ff == OP_READ && idx_ok_ff) begin
            pr_in = chan_v[0][CHAN_W-1:4];
            pg_in = chan_v[1][CHAN_W-1:4];
            pb_in = chan_v[2][CHAN_W-1:4];
         end else begin
            pr_in = '0;
            pg_in = '0;
            pb_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pix_ff      <= pix_in;
      idx_ok_ff   <= idx_ok_in;
      ridx_ff     <= ridx_in;
      init_i_ff   <= init_i_in;
      scan_addr_ff <= scan_addr_in;
      eval_idx_ff <= eval_idx_in;
      best_ff     <= best_in;
      bestd_ff    <= bestd_in;
      k_ff        <= k_in;
      hi_ff       <= hi_in;
      win_ff      <= win_in;
      pr_ff       <= pr_in;
      pg_ff       <= pg_in;
      pb_ff       <= pb_in;
      if (cmd.upd_mul) begin
         ge_ff   <= ge_in;
         prod_ff <= prod_in;
      end
      if (reset) begin
         issue_ff     <= 1'b0;
         first_ff     <= 1'b0;
         lr_ff        <= LEARN_RATE_START;
         rad_ff       <= '0;
         seen_ff      <= '0;
         cd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         issue_ff     <= issue_in;
         first_ff     <= first_in;
         lr_ff        <= lr_in;
         rad_ff       <= rad_in;
         seen_ff      <= seen_in;
         cd_ff        <= cd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      status.div_done  = div_done;
      status.init_last = init_i_ff == last_idx;
      status.scan_done = issue_ff && (CNT_W'(eval_idx_ff) == last_idx);
      status.upd_last  = !first_ff && (k_ff == hi_ff);
      status.cd_zero   = cd_ff == '0;
      status.rad_live  = (cfg.sample_count != '0) && (seen_w < sc_w);
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_winner_index  = win_ff;
   assign rsp_palette_red   = pr_ff;
   assign rsp_palette_green = pg_ff;
   assign rsp_palette_blue  = pb_ff;

endmodule

// ----- hdl/npt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Palette trainer controller
// State machine that sequences each operation through the datapath.
// ----------------------------------------------------------------------------
module npt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_op,
   input  npt_pkg::npt_status_type status,
   output npt_pkg::npt_cmd_type    cmd
);
   import npt_pkg::*;

   typedef enum logic [14:0] {
      ST_IDLE       = 15'h0001,
      ST_INIT_DIV   = 15'h0002,
      ST_INIT_WAIT  = 15'h0004,
      ST_SCAN       = 15'h0008,
      ST_UPD_START  = 15'h0010,
      ST_UPD_RD     = 15'h0020,
      ST_UPD_MUL    = 15'h0040,
      ST_UPD_WR     = 15'h0080,
      ST_DEC        = 15'h0100,
      ST_ALPHA_GO   = 15'h0200,
      ST_ALPHA_WAIT = 15'h0400,
      ST_RAD_GO     = 15'h0800,
      ST_RAD_WAIT   = 15'h1000,
      ST_RD_ADDR    = 15'h2000,
      ST_FIN        = 15'h4000
   } npt_state_type;

   npt_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = state_ff != ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_op)
                  OP_INIT: begin
                     cmd.init_start = 1'b1;
                     state_in       = ST_INIT_DIV;
                  end
                  OP_EPOCH: begin
                     cmd.epoch = 1'b1;
                     state_in  = ST_FIN;
                  end
                  OP_TRAIN: begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_RD_ADDR;
                  end
               endcase
            end
         end
         ST_INIT_DIV: begin
            cmd.div_init = 1'b1;
            state_in     = ST_INIT_WAIT;
         end
         ST_INIT_WAIT: begin
            if (status.div_done) begin
               cmd.init_write = 1'b1;
               state_in       = status.init_last ? ST_FIN : ST_INIT_DIV;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_UPD_START;
            end
         end
         ST_UPD_START: begin
            cmd.upd_start = 1'b1;
            state_in      = ST_UPD_RD;
         end
         ST_UPD_RD: begin
            cmd.upd_read = 1'b1;
            state_in     = ST_UPD_MUL;
         end
         ST_UPD_MUL: begin
            cmd.upd_mul = 1'b1;
            state_in    = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            cmd.upd_write = 1'b1;
            state_in      = status.upd_last ? ST_DEC : ST_UPD_RD;
         end
         ST_DEC: begin
            if (status.cd_zero) begin
               state_in = ST_ALPHA_GO;
            end else begin
               cmd.dec_finish = 1'b1;
               state_in       = ST_FIN;
            end
         end
         ST_ALPHA_GO: begin
            cmd.div_alpha = 1'b1;
            state_in      = ST_ALPHA_WAIT;
         end
         ST_ALPHA_WAIT: begin
            if (status.div_done) begin
               cmd.alpha_write = 1'b1;
               state_in        = ST_RAD_GO;
            end
         end
         ST_RAD_GO: begin
            if (status.rad_live) begin
               cmd.div_rad = 1'b1;
               state_in    = ST_RAD_WAIT;
            end else begin
               cmd.rad_write  = 1'b1;
               cmd.dec_finish = 1'b1;
               state_in       = ST_FIN;
            end
         end
         ST_RAD_WAIT: begin
            if (status.div_done) begin
               cmd.rad_write  = 1'b1;
               cmd.dec_finish = 1'b1;
               state_in       = ST_FIN;
            end
         end
         ST_RD_ADDR: begin
            cmd.rd_read = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- bench/npt_checker.sv -----
// ----------------------------------------------------------------------------
// Palette trainer checker
// Follows register writes and accepted words of the trainer core, predicts each
// result word from its own copy of the palette and compares it with the block.
// ----------------------------------------------------------------------------
module npt_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_op,
   input  logic [7:0]                     req_pixel_red,
   input  logic [7:0]                     req_pixel_green,
   input  logic [7:0]                     req_pixel_blue,
   input  logic [7:0]                     req_entry_index,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [7:0]                     rsp_winner_index,
   input  logic [7:0]                     rsp_palette_red,
   input  logic [7:0]                     rsp_palette_green,
   input  logic [7:0]                     rsp_palette_blue,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic                           csr_pready,
   input  logic [npt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output int                             fail_count,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import npt_pkg::*;

   typedef struct packed {
      logic [7:0] winner;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } answer_type;

   logic [11:0] pal_red [256];
   logic [11:0] pal_green [256];
   logic [11:0] pal_blue [256];
   logic [10:0] rate;
   logic [5:0]  radius;
   logic [23:0] seen;
   logic [17:0] countdown;
   npt_cfg_type cfg;
   answer_type  answers [$];

   function automatic logic [11:0] pull_toward(logic [11:0] v, int p, int a);
      int x;
      x = v;
      if (x >= p) return 12'(x - (a * (x - p)) / 1024);
      return 12'(x + (a * (p - x)) / 1024);
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch at %0t: %s is %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic predict_word(output answer_type ans);
      int count, r, g, b, best, bestd, d, lo, hi, rad, dv, ivl, rd;
      count = (cfg.neuron_count == 0) ? 1 : (cfg.neuron_count > 256 ? 256 : cfg.neuron_count);
      ans = '0;
      case (req_op)
         OP_INIT: begin
            for (int i = 0; i < count; i++) begin
               pal_red[i] = 12'((i << 12) / count);
               pal_green[i] = pal_red[i];
               pal_blue[i] = pal_red[i];
            end
         end
         OP_EPOCH: begin
            rate = LEARN_RATE_START;
            radius = cfg.start_radius >> 6;
            seen = 0;
            countdown = 0;
         end
         OP_TRAIN: begin
            r = req_pixel_red << 4;
            g = req_pixel_green << 4;
            b = req_pixel_blue << 4;
            best = 0;
            bestd = 32'h7fffffff;
            for (int i = 0; i < count; i++) begin
               d = ((pal_red[i] > r) ? pal_red[i] - r : r - pal_red[i])
                 + ((pal_green[i] > g) ? pal_green[i] - g : g - pal_green[i])
                 + ((pal_blue[i] > b) ? pal_blue[i] - b : b - pal_blue[i]);
               if (d < bestd) begin
                  bestd = d;
                  best = i;
               end
            end
            pal_red[best] = pull_toward(pal_red[best], r, rate);
            pal_green[best] = pull_toward(pal_green[best], g, rate);
            pal_blue[best] = pull_toward(pal_blue[best], b, rate);
            rd = int'(radius);
            lo = (best - rd < 0) ? 0 : best - rd;
            hi = (best + rd > count - 1) ? count - 1 : best + rd;
            for (int k = lo; k <= hi; k++) begin
               pal_red[k] = pull_toward(pal_red[k], r, rate);
               pal_green[k] = pull_toward(pal_green[k], g, rate);
               pal_blue[k] = pull_toward(pal_blue[k], b, rate);
            end
            if (countdown == 0) begin
               dv = cfg.alpha_divisor ? cfg.alpha_divisor : 1;
               ivl = cfg.decay_interval ? cfg.decay_interval : 1;
               rate = 11'(rate - rate / dv);
               rad = 0;
               if (cfg.sample_count != 0 && seen < cfg.sample_count)
                  rad = int'((longint'(cfg.start_radius) * (cfg.sample_count - seen))
                             / cfg.sample_count);
               radius = (rad <= 1) ? 6'd0 : 6'(rad);
               countdown = 18'(ivl - 1);
            end else begin
               countdown--;
            end
            if (seen != 24'hffffff) seen++;
            ans.winner = 8'(best);
         end
         default: begin
            ans.red = pal_red[req_entry_index][11:4];
            ans.green = pal_green[req_entry_index][11:4];
            ans.blue = pal_blue[req_entry_index][11:4];
         end
      endcase
   endtask

   always @(posedge clock) begin
      answer_type ans;
      if (reset) begin
         rate <= LEARN_RATE_START;
         radius <= '0;
         seen <= '0;
         countdown <= '0;
         cfg <= '{9'd256, 24'd52428, 7'd31, 18'd524, 6'd32};
         answers.delete();
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (3'(csr_paddr >> 2))
               REG_NEURON_COUNT:   cfg.neuron_count = csr_pwdata[8:0];
               REG_SAMPLE_COUNT:   cfg.sample_count = csr_pwdata[23:0];
               REG_ALPHA_DIVISOR:  cfg.alpha_divisor = csr_pwdata[6:0];
               REG_DECAY_INTERVAL: cfg.decay_interval = csr_pwdata[17:0];
               REG_START_RADIUS:   cfg.start_radius = csr_pwdata[5:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (answers.size() == 0) begin
               report("unexpected result word", 1, 0);
            end else begin
               ans = answers.pop_front();
               if (rsp_winner_index !== ans.winner)
                  report("winner_index", rsp_winner_index, ans.winner);
               if (rsp_palette_red !== ans.red)
                  report("palette_red", rsp_palette_red, ans.red);
               if (rsp_palette_green !== ans.green)
                  report("palette_green", rsp_palette_green, ans.green);
               if (rsp_palette_blue !== ans.blue)
                  report("palette_blue", rsp_palette_blue, ans.blue);
            end
         end
         if (req_valid && !req_stall) begin
            predict_word(ans);
            answers.push_back(ans);
         end
      end
      pending <= answers.size();
   end

endmodule

// ----- bench/tb_neural_palette_trainer_core.sv -----
// ----------------------------------------------------------------------------
// Palette trainer testbench
// Runs the trainer core through a series of register settings, each starting
// with an init and an epoch, then directed and random train, read, init and
// epoch words under varying handshake gaps. The checker grades every result.
// ----------------------------------------------------------------------------
module tb_neural_palette_trainer_core;
   timeunit 1ns;
   timeprecision 1ps;
   import npt_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_op;
   logic [7:0]            req_pixel_red;
   logic [7:0]            req_pixel_green;
   logic [7:0]            req_pixel_blue;
   logic [7:0]            req_entry_index;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [7:0]            rsp_winner_index;
   logic [7:0]            rsp_palette_red;
   logic [7:0]            rsp_palette_green;
   logic [7:0]            rsp_palette_blue;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    pending;

   int send_idle;
   int recv_idle;
   int hold_cycles;
   int cur_count;
   int written_top;
   int words_sent;
   int trains_sent;

   neural_palette_trainer_core u_top (.*);

   npt_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   task automatic send_word(logic [1:0] op, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, logic [7:0] idx);
      logic taken;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         req_op <= 2'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_pixel_red <= r;
      req_pixel_green <= g;
      req_pixel_blue <= b;
      req_entry_index <= idx;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      words_sent++;
      if (op == OP_TRAIN) trains_sent++;
      if (op == OP_INIT && cur_count > written_top) written_top = cur_count;
   endtask

   task automatic send_random_word();
      int pick;
      pick = $urandom_range(99);
      if (pick < 75)
         send_word(OP_TRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else if (pick < 88)
         send_word(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom_range(written_top - 1)));
      else if (pick < 94)
         send_word(OP_EPOCH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else
         send_word(OP_INIT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic setup_phase(int count, int samples, int divisor, int interval,
                              int radius);
      wait_drained();
      write_reg(REG_NEURON_COUNT, count);
      write_reg(REG_SAMPLE_COUNT, samples);
      write_reg(REG_ALPHA_DIVISOR, divisor);
      write_reg(REG_DECAY_INTERVAL, interval);
      write_reg(REG_START_RADIUS, radius);
      cur_count = (count == 0) ? 1 : (count > 256 ? 256 : count);
      send_word(OP_INIT, 8'hff, 8'hff, 8'hff, 8'hff);
      send_word(OP_EPOCH, 8'h00, 8'h00, 8'h00, 8'h00);
   endtask

   initial begin
      int cfg_set [7][5] = '{
         '{8, 20, 30, 1, 32},
         '{1, 1, 115, 1, 0},
         '{16, 16777215, 0, 0, 63},
         '{0, 0, 127, 3, 5},
         '{300, 40, 45, 262143, 32},
         '{12, 100, 31, 5, 10},
         '{511, 60, 30, 2, 32}};
      int n_words;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_INIT;
      req_pixel_red = '0;
      req_pixel_green = '0;
      req_pixel_blue = '0;
      req_entry_index = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hold_cycles = 0;
      send_idle = 27;
      recv_idle = 56;
      written_top = 0;
      words_sent = 0;
      trains_sent = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < 11; p++) begin
         if (p == 4) begin
            send_idle = 56;
            recv_idle = 27;
         end else if (p == 8) begin
            send_idle = 0;
            recv_idle = 0;
         end
         if (p < 7)
            setup_phase(cfg_set[p][0], cfg_set[p][1], cfg_set[p][2], cfg_set[p][3],
                        cfg_set[p][4]);
         else
            setup_phase($urandom_range(1, 40), $urandom_range(1, 300),
                        $urandom_range(30, 115), $urandom_range(1, 20),
                        $urandom_range(0, 63));
         if (p == 0) begin
            send_word(OP_TRAIN, 8'h00, 8'h00, 8'h00, 8'h00);
            send_word(OP_TRAIN, 8'hff, 8'hff, 8'hff, 8'h00);
            send_word(OP_TRAIN, 8'hff, 8'h00, 8'h80, 8'hff);
            send_word(OP_TRAIN, 8'h00, 8'hff, 8'h00, 8'h00);
            send_word(OP_TRAIN, 8'haa, 8'h55, 8'haa, 8'h55);
            send_word(OP_TRAIN, 8'h55, 8'haa, 8'h55, 8'haa);
            send_word(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00);
            send_word(OP_READ, 8'hff, 8'hff, 8'hff, 8'h07);
            send_word(OP_EPOCH, 8'h00, 8'h00, 8'h00, 8'h00);
            send_word(OP_TRAIN, 8'h10, 8'h10, 8'h10, 8'h00);
            send_word(OP_INIT, 8'h00, 8'h00, 8'h00, 8'h00);
            send_word(OP_READ, 8'h00, 8'h00, 8'h00, 8'h03);
         end
         if (p == 5) hold_cycles = 3000;
         n_words = (cur_count > 64) ? 25 : 55;
         repeat (n_words) send_random_word();
      end

      wait_drained();
      $display("Sent %0d words (%0d training samples) over 11 register settings,",
               words_sent, trains_sent);
      $display("with neuron counts from 1 to 256 and a long result back-pressure stretch.");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
